FILE: rtl/core/ssenc_pkg.sv
// ============================================================================
// ssenc_pkg: shared types and constants of the seven-segment text encoder
// Holds the segment ROM, the character codes that steer the encoder and the
// digit-write record that travels through the result queue.
// ============================================================================
package ssenc_pkg;

    localparam int DIGITS_DEFAULT = 8;
    localparam int POS_W          = 6;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SKIP  = 8'h7A;
    localparam logic [6:0] CHAR_BLANK = 7'd32;
    localparam logic [7:0] POINT_BIT  = 8'b1000_0000;

    typedef struct packed {
        logic [3:0] register_address;
        logic [7:0] segment_pattern;
        logic       final_of_run;
    } ssenc_result_t;

    localparam logic [7:0] SEG_ROM [128] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h01, 8'h80, 8'h00,
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h00,
        8'h37, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h00, 8'h00,
        8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08,
        8'h00, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h00,
        8'h37, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h15, 8'h1D,
        8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Codes above the ROM range show as a blank.
    function automatic logic [7:0] seg_pattern(input logic [7:0] ch);
        logic [6:0] idx;
        idx = ch[7] ? CHAR_BLANK : ch[6:0];
        return SEG_ROM[idx];
    endfunction

endpackage

FILE: rtl/core/ssenc_channels.sv
// ============================================================================
// ssenc channels: valid/ready interfaces of the seven-segment text encoder
// The text channel carries message characters, the digit channel carries
// digit-register writes.
// ============================================================================
interface ssenc_text_if;
    logic              valid;
    logic              ready;
    logic [7:0]        character;
    logic signed [4:0] start_position;
    logic              first;
    logic              last;

    modport source (output valid, character, start_position, first, last, input ready);
    modport sink   (input valid, character, start_position, first, last, output ready);
endinterface

interface ssenc_digit_if;
    logic       valid;
    logic       ready;
    logic [3:0] register_address;
    logic [7:0] segment_pattern;
    logic       final_of_run;

    modport source (output valid, register_address, segment_pattern, final_of_run,
                    input ready);
    modport sink   (input valid, register_address, segment_pattern, final_of_run,
                    output ready);
endinterface

FILE: rtl/core/seven_segment_text_encoder.sv
// ============================================================================
// seven_segment_text_encoder: text to seven-segment digit-register writes
// Turns a character stream into register writes for a multi-digit driver,
// folding a following dot into the decimal point of the previous digit.
// ============================================================================
// Usage:
// The text channel takes one character per request. A request with first set
// starts a message at start_position; a request with last set ends it and
// flushes the character held back as lookahead. Each request causes zero, one
// or two digit writes on the digit channel; final_of_run marks the last write
// caused by a request.
// The encoder works on a request in the cycle it is accepted: the lookahead
// state, the segment ROM and the position compares all settle in that cycle,
// and the writes enter a four-entry result queue. The first write is
// registered in the queue before it shows on the digit channel.
// Throughput is one request per cycle as long as the digit channel drains:
// text.ready is high while the queue holds two entries or fewer, so the only
// limit is the digit channel's single write per cycle when requests cause
// two writes each.
// Reset clears the lookahead, the position (to zero) and the queue. When the
// digit receiver stalls, the head write holds steady and the queue fills,
// after which text.ready drops until room for two writes opens again.
// ============================================================================
module seven_segment_text_encoder
    import ssenc_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ssenc_text_if.sink           text,
    ssenc_digit_if.source        digit
);

    localparam logic signed [POS_W-1:0] POS_LAST = POS_W'(DIGITS);
    localparam logic signed [POS_W-1:0] POS_SAT  = POS_W'(DIGITS + 1);
    localparam logic [3:0]              ADDR_TOP = 4'(DIGITS + 1);

    // Lookahead state.
    logic                     held_valid_reg, held_valid_next;
    logic [7:0]               held_char_reg, held_char_next;
    logic                     held_visible_reg, held_visible_next;
    logic [3:0]               held_addr_reg, held_addr_next;
    logic signed [POS_W-1:0]  position_reg, position_next;

    logic                     accept;
    logic signed [POS_W-1:0]  start_pos;
    logic signed [POS_W-1:0]  pos_eff;
    logic                     held_eff;
    logic                     is_dot;
    logic                     swallow;
    logic                     take;
    logic                     flush_res_valid;
    logic                     last_res_valid;
    ssenc_result_t            flush_res;
    ssenc_result_t            last_res;
    ssenc_result_t            push_a;
    logic [1:0]               push_cnt;
    ssenc_result_t            head;
    logic [QCNT_W-1:0]        q_count;

    assign accept = text.valid && text.ready;

    always_comb
    begin
        // A new message drops any pending character and loads the position,
        // clamped at one past the last digit.
        start_pos = POS_W'(text.start_position);
        if (text.first)
        begin
            held_eff = 1'b0;
            pos_eff  = (start_pos > POS_SAT) ? POS_SAT : start_pos;
        end
        else
        begin
            held_eff = held_valid_reg;
            pos_eff  = position_reg;
        end

        // The pending character is written first, with its point set when a
        // dot follows. A dot after a dot does not get swallowed.
        is_dot          = (text.character == CHAR_DOT);
        flush_res_valid = held_eff && held_visible_reg;
        flush_res.register_address = held_addr_reg;
        flush_res.segment_pattern  = seg_pattern(held_char_reg) | (is_dot ? POINT_BIT : 8'h00);
        swallow = held_eff && is_dot && (held_char_reg != CHAR_DOT);

        // The incoming character is held when it sits at position zero or on
        // the display and is not the skip character.
        take = !swallow && (pos_eff >= 0) && (pos_eff <= POS_LAST)
               && (text.character != CHAR_SKIP);

        held_char_next    = held_char_reg;
        held_visible_next = held_visible_reg;
        held_addr_next    = held_addr_reg;
        if (take)
        begin
            held_char_next    = text.character;
            held_visible_next = (pos_eff >= 1);
            held_addr_next    = ADDR_TOP - pos_eff[3:0];
        end

        position_next = pos_eff;
        if (!swallow && pos_eff <= POS_LAST)
            position_next = pos_eff + POS_W'(1);

        // On the last character the newly held one is flushed without a point.
        last_res_valid = text.last && take && held_visible_next;
        last_res.register_address = held_addr_next;
        last_res.segment_pattern  = seg_pattern(text.character);
        last_res.final_of_run     = 1'b1;
        held_valid_next           = take && !text.last;

        flush_res.final_of_run = !last_res_valid;

        push_a   = flush_res_valid ? flush_res : last_res;
        push_cnt = 2'(flush_res_valid) + 2'(last_res_valid);
        if (!accept)
            push_cnt = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            position_reg   <= '0;
        end
        else if (accept)
        begin
            held_valid_reg <= held_valid_next;
            position_reg   <= position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_char_reg    <= held_char_next;
            held_visible_reg <= held_visible_next;
            held_addr_reg    <= held_addr_next;
        end
    end

    ssenc_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (last_res),
        .pop      (digit.valid && digit.ready),
        .head     (head),
        .count    (q_count)
    );

    // Room for two writes is needed before a request may enter.
    assign text.ready = (q_count <= QCNT_W'(QUEUE_DEPTH - 2));

    assign digit.valid            = (q_count != '0);
    assign digit.register_address = head.register_address;
    assign digit.segment_pattern  = head.segment_pattern;
    assign digit.final_of_run     = head.final_of_run;

endmodule

FILE: rtl/core/ssenc_result_queue.sv
// ============================================================================
// ssenc_result_queue: shifting queue of digit writes
// Takes up to two results per cycle and hands them out one per cycle from
// its head entry while pop is set.
// ============================================================================
module ssenc_result_queue
    import ssenc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  ssenc_result_t       push_a,
    input  ssenc_result_t       push_b,
    input  logic                pop,
    output ssenc_result_t       head,
    output logic [QCNT_W-1:0]   count
);

    ssenc_result_t            entry_reg [QUEUE_DEPTH];
    ssenc_result_t            entry_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0]        count_reg;
    logic [QCNT_W-1:0]        count_next;
    logic [QCNT_W-1:0]        kept;

    // Entries shift toward the head on a pop; new results land right after
    // the entries that stay.
    always_comb
    begin
        kept = count_reg - QCNT_W'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i < QUEUE_DEPTH - 1)
                entry_next[i] = entry_reg[i + 1];
            else
                entry_next[i] = entry_reg[i];
            if (push_cnt != 2'd0 && kept == QCNT_W'(i))
                entry_next[i] = push_a;
            if (push_cnt == 2'd2 && kept + QCNT_W'(1) == QCNT_W'(i))
                entry_next[i] = push_b;
        end
        count_next = kept + QCNT_W'(push_cnt);
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head  = entry_reg[0];
    assign count = count_reg;

endmodule

FILE: rtl/core/ssenc_checker.sv
// ============================================================================
// ssenc_checker: port-level checks of the seven-segment text encoder
// Watches the text and digit channels and flags write ordering, address
// and stalled-write errors.
// ============================================================================
module ssenc_checker
    import ssenc_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    input  logic       text_ready,
    input  logic       digit_valid,
    input  logic       digit_ready,
    input  logic [3:0] register_address,
    input  logic [7:0] segment_pattern,
    input  logic       final_of_run
);

    // Writes only go to digit registers that exist.
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (register_address >= 4'd1) && (register_address <= 4'(DIGITS)))
    else $error("digit write to a register outside the display");

    // Both writes of one request are queued together, so the second one is
    // ready right after the first.
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_ready && !final_of_run |=> digit_valid)
    else $error("second write of a request did not follow its first");

    // A write only appears after a request was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digit_valid) |-> $past(text_valid && text_ready))
    else $error("digit write without a preceding request");

    // A stalled write holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit_ready |=> digit_valid
            && $stable({register_address, segment_pattern, final_of_run}))
    else $error("stalled digit write changed");

endmodule

bind seven_segment_text_encoder ssenc_checker #(.DIGITS(DIGITS)) u_ssenc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .text_valid       (text.valid),
    .text_ready       (text.ready),
    .digit_valid      (digit.valid),
    .digit_ready      (digit.ready),
    .register_address (digit.register_address),
    .segment_pattern  (digit.segment_pattern),
    .final_of_run     (digit.final_of_run)
);

FILE: sim/seven_segment_text_encoder_tb.sv
// ============================================================================
// seven_segment_text_encoder_tb: self-checking regression for the text encoder
// Drives character requests through the text channel, keeps its own model of
// the lookahead, dot folding and position logic, and checks every digit write
// in order against the writes that model expects, under random idling on both
// channels and one long stall of the digit receiver.
// ============================================================================
module seven_segment_text_encoder_tb;

    import ssenc_pkg::ssenc_result_t;

    // Display geometry of the instance under test (the block's default).
    localparam int DIGITS = 8;

    // Character codes that steer the encoder.
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] SKIP_CHAR  = 8'h7A;
    localparam logic [7:0] POINT_MASK = 8'h80;

    // Run limits. The watchdog limit sits well above the slowest legal run.
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int END_SETTLE   = 16;
    localparam int REPORT_LIMIT = 25;
    localparam int HOLD_OFF_LEN = 300;

    // Stall patterns of the digit receiver.
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_RANDOM,
        DRAIN_PERIODIC,
        DRAIN_SPARSE
    } drain_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    ssenc_text_if  text_ch ();
    ssenc_digit_if digit_ch ();

    seven_segment_text_encoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .digit (digit_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the encoder state. It starts at the reset values, and reset is
    // applied only once, so it never needs clearing.
    // ------------------------------------------------------------------------
    bit         shadow_held_valid   = 1'b0;
    logic [7:0] shadow_held_char    = 8'h00;
    bit         shadow_held_visible = 1'b0;
    logic [3:0] shadow_held_reg     = 4'h0;
    int         shadow_position     = 0;

    // Digit writes predicted but not yet seen on the digit channel, oldest first.
    ssenc_result_t digit_expected[$];

    int error_count        = 0;
    int requests_taken     = 0;
    int writes_checked     = 0;
    int double_write_steps = 0;
    int input_stall_cycles = 0;
    int cycle_count        = 0;

    // Sender burst control; steady_send turns the gaps off.
    int burst_left  = 0;
    bit steady_send = 1'b0;

    // A nonzero value asks the receiver for a stall of that many cycles.
    int hold_off_request = 0;

    // Segment glyphs of the hex digits, shared by the control codes 0..15,
    // the decimal digits and the letters A..F in both cases.
    function automatic logic [7:0] hex_glyph(input logic [3:0] d);
        case (d)
            4'h0: return 8'h7E;
            4'h1: return 8'h30;
            4'h2: return 8'h6D;
            4'h3: return 8'h79;
            4'h4: return 8'h33;
            4'h5: return 8'h5B;
            4'h6: return 8'h5F;
            4'h7: return 8'h70;
            4'h8: return 8'h7F;
            4'h9: return 8'h7B;
            4'hA: return 8'h77;
            4'hB: return 8'h1F;
            4'hC: return 8'h0D;
            4'hD: return 8'h3D;
            4'hE: return 8'h4F;
            default: return 8'h47;
        endcase
    endfunction

    // Segment pattern of one character; codes above 127 show as a blank, and
    // a blank lights nothing.
    function automatic logic [7:0] glyph_of(input logic [7:0] ch);
        if (ch[7])
            return 8'h00;
        if (ch < 8'h10)
            return hex_glyph(ch[3:0]);
        if (ch >= "0" && ch <= "9")
            return hex_glyph(4'(ch - "0"));
        if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f"))
            return hex_glyph(4'(ch[2:0] + 4'd9));
        case (ch)
            ",", ".": return 8'h80;
            "-":      return 8'h01;
            "H", "h": return 8'h37;
            "L", "l": return 8'h0E;
            "P", "p": return 8'h67;
            "_":      return 8'h08;
            "n":      return 8'h15;
            "o":      return 8'h1D;
            default:  return 8'h00;
        endcase
    endfunction

    // Works out the digit writes that one accepted request causes and queues
    // them. The pending character goes out first, with the point if a dot
    // follows; then the new character is held, skipped or folded away; then
    // a last request flushes whatever is held.
    task automatic predict_digit_writes(input logic [7:0] ch, input logic signed [4:0] start,
                                        input logic first, input logic last);
        ssenc_result_t writes[2];
        int            n;
        bit            dot_follows;
        bit            folded;
        n      = 0;
        folded = 1'b0;
        if (first)
        begin
            // A character still held from the previous message is dropped.
            shadow_held_valid = 1'b0;
            shadow_position   = (int'(start) > DIGITS + 1) ? DIGITS + 1 : int'(start);
        end
        if (shadow_held_valid)
        begin
            dot_follows = (ch == DOT_CHAR);
            if (shadow_held_visible)
            begin
                writes[n].register_address = shadow_held_reg;
                writes[n].segment_pattern  = glyph_of(shadow_held_char)
                                             | (dot_follows ? POINT_MASK : 8'h00);
                writes[n].final_of_run     = 1'b0;
                n++;
            end
            shadow_held_valid = 1'b0;
            // A dot after a dot lights the point and is then shown itself.
            folded = dot_follows && (shadow_held_char != DOT_CHAR);
        end
        if (!folded)
        begin
            if (shadow_position >= 0 && shadow_position <= DIGITS && ch != SKIP_CHAR)
            begin
                shadow_held_valid   = 1'b1;
                shadow_held_char    = ch;
                shadow_held_visible = (shadow_position >= 1);
                shadow_held_reg     = 4'(DIGITS + 1 - shadow_position);
            end
            if (shadow_position <= DIGITS)
                shadow_position++;
        end
        if (last && shadow_held_valid)
        begin
            if (shadow_held_visible)
            begin
                writes[n].register_address = shadow_held_reg;
                writes[n].segment_pattern  = glyph_of(shadow_held_char);
                writes[n].final_of_run     = 1'b0;
                n++;
            end
            shadow_held_valid = 1'b0;
        end
        if (n > 0)
            writes[n - 1].final_of_run = 1'b1;
        if (n == 2)
            double_write_steps++;
        for (int k = 0; k < n; k++)
            digit_expected.push_back(writes[k]);
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before any of the
    // edge's nonblocking updates land, so the order of processes does not
    // matter. A request taken at an edge is predicted at that edge; its first
    // write cannot appear before the next one.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        ssenc_result_t want;
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                requests_taken++;
                predict_digit_writes(text_ch.character, text_ch.start_position,
                                     text_ch.first, text_ch.last);
            end
            if (text_ch.valid && !text_ch.ready)
                input_stall_cycles++;
            if (digit_ch.valid && digit_ch.ready)
            begin
                writes_checked++;
                if (digit_expected.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected digit write, expected none, actual %0h/%0h/%0b",
                                 $time, digit_ch.register_address, digit_ch.segment_pattern,
                                 digit_ch.final_of_run);
                end
                else
                begin
                    want = digit_expected.pop_front();
                    if (digit_ch.register_address !== want.register_address)
                        report_mismatch("register_address", want.register_address,
                                        digit_ch.register_address);
                    if (digit_ch.segment_pattern !== want.segment_pattern)
                        report_mismatch("segment_pattern", want.segment_pattern,
                                        digit_ch.segment_pattern);
                    if (digit_ch.final_of_run !== want.final_of_run)
                        report_mismatch("final_of_run", want.final_of_run,
                                        digit_ch.final_of_run);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Digit receiver. It switches at random between stall patterns: always
    // ready, random, a fixed period with a random phase, and rare stalls. A
    // hold-off request overrides all of them and is counted down here.
    // ------------------------------------------------------------------------
    drain_mode_t drain_mode   = DRAIN_FREE;
    int          mode_left    = 0;
    int          drain_period = 3;
    int          drain_phase  = 0;
    int          hold_off_left = 0;

    always @(posedge clk)
    begin
        if (hold_off_request != 0)
        begin
            hold_off_left    = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            digit_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                drain_mode   = drain_mode_t'($urandom_range(0, 3));
                mode_left    = $urandom_range(20, 250);
                drain_period = $urandom_range(2, 5);
                drain_phase  = $urandom_range(0, 4);
            end
            mode_left--;
            drain_phase++;
            case (drain_mode)
                DRAIN_FREE:     digit_ch.ready <= 1'b1;
                DRAIN_RANDOM:   digit_ch.ready <= ($urandom_range(0, 99) < 60);
                DRAIN_PERIODIC: digit_ch.ready <= ((drain_phase % drain_period) != 0);
                default:        digit_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d digit writes outstanding.",
                     cycle_count, digit_expected.size());
            $display("seven_segment_text_encoder regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Requests go out in bursts of random length, and valid drops
    // between bursts unless steady_send is set. Valid is only ever assigned
    // once per edge, so a burst keeps it high from one request to the next.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [7:0] ch, input int start,
                                input bit first, input bit last);
        int gap;
        if (!steady_send && burst_left <= 0)
        begin
            text_ch.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            // Now and then a long burst, so that stretches with no gaps occur.
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        text_ch.valid          <= 1'b1;
        text_ch.character      <= ch;
        text_ch.start_position <= start[4:0];
        text_ch.first          <= first;
        text_ch.last           <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Drops valid and waits until every predicted write has been checked. It
    // steps past a clock edge first, so the monitor has predicted the last request taken.
    task automatic wait_for_drain;
        text_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (digit_expected.size() != 0)
            @(posedge clk);
    endtask

    // Mostly printable text with plenty of dots and skips, plus the control
    // codes and the codes above the ROM.
    function automatic logic [7:0] pick_character;
        case ($urandom_range(0, 11))
            0, 1, 2: return 8'("0" + $urandom_range(0, 9));
            3, 4:    return DOT_CHAR;
            5:       return SKIP_CHAR;
            6:       return 8'("A" + $urandom_range(0, 25));
            7:       return 8'("a" + $urandom_range(0, 25));
            8:       return 8'($urandom_range(1, 15));
            9:       return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed cases: a message before any first, a dot at position zero, dot
    // after dot, the skip character, the field extremes, position saturation,
    // a held character dropped by a new first, and a step with two writes.
    // ------------------------------------------------------------------------
    task automatic test_directed_cases;
        // No first yet: position zero holds the 8 without showing it and eats
        // the dot; the A lands at position one.
        send_request("8", 0, 1'b0, 1'b0);
        send_request(DOT_CHAR, 0, 1'b0, 1'b0);
        send_request("A", 0, 1'b0, 1'b1);
        // Dot after dot, then a skip that still advances, then a folded dot
        // on a last request.
        send_request(DOT_CHAR, 1, 1'b1, 1'b0);
        send_request(DOT_CHAR, 0, 1'b0, 1'b0);
        send_request(SKIP_CHAR, 0, 1'b0, 1'b0);
        send_request("H", 0, 1'b0, 1'b0);
        send_request(DOT_CHAR, 0, 1'b0, 1'b1);
        // The rightmost digit, then a character past the end.
        send_request(8'h7F, DIGITS, 1'b1, 1'b0);
        send_request(8'h01, 0, 1'b0, 1'b1);
        // Field extremes: lowest start, highest start saturating, top codes.
        send_request(8'hFF, -16, 1'b1, 1'b1);
        send_request(8'h80, 15, 1'b1, 1'b0);
        send_request(DOT_CHAR, 0, 1'b0, 1'b1);
        send_request(8'h55, -1, 1'b1, 1'b0);
        send_request("0", 0, 1'b0, 1'b0);
        send_request(DOT_CHAR, 0, 1'b0, 1'b0);
        send_request("5", 0, 1'b0, 1'b1);
        // A held character is dropped when a new message starts.
        send_request("E", 3, 1'b1, 1'b0);
        send_request("F", 5, 1'b1, 1'b1);
        // Two writes from one request: the held 1 and the flushed code above
        // the ROM, which shows as a blank.
        send_request("1", 2, 1'b1, 1'b0);
        send_request(8'hAA, 0, 1'b0, 1'b1);
        send_request("-", DIGITS + 1, 1'b1, 1'b1);
        send_request("o", 6, 1'b1, 1'b1);
        wait_for_drain();
    endtask

    // Well-formed messages with random content and start, with some messages
    // abandoned without last and some stray requests between messages.
    task automatic test_message_stream;
        int  sent;
        int  length;
        int  start;
        bit  closed;
        sent = 0;
        while (sent < 1350)
        begin
            if ($urandom_range(0, 9) == 0)
                start = $urandom_range(0, 31) - 16;
            else
                start = $urandom_range(0, 11) - 2;
            length = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 20)
                                                   : $urandom_range(1, 10);
            closed = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < length; k++)
                send_request(pick_character(), (k == 0) ? start : $urandom_range(0, 31) - 16,
                             k == 0, closed && (k == length - 1));
            sent += length;
            if ($urandom_range(0, 7) == 0)
            begin
                send_request(pick_character(), $urandom_range(0, 31) - 16, 1'b0,
                             bit'($urandom_range(0, 1)));
                sent++;
            end
        end
        wait_for_drain();
    endtask

    // The receiver stalls for a long stretch while requests keep coming with
    // no gaps, so the result queue fills and the text channel must stall.
    task automatic test_input_backpressure;
        steady_send      = 1'b1;
        hold_off_request = HOLD_OFF_LEN;
        for (int k = 0; k < 80; k++)
            send_request(pick_character(), (k % 10) - 1, (k % 6) == 0, (k % 3) == 2);
        steady_send = 1'b0;
        wait_for_drain();
    endtask

    // Every field random, the start over its whole range and the character over 1..255.
    task automatic test_field_noise;
        for (int k = 0; k < 300; k++)
            send_request(8'($urandom_range(1, 255)), $urandom_range(0, 31) - 16,
                         bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequencer: reset once, then the tests in turn, then the verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        text_ch.valid          = 1'b0;
        text_ch.character      = 8'h20;
        text_ch.start_position = 5'sd0;
        text_ch.first          = 1'b0;
        text_ch.last           = 1'b0;
        digit_ch.ready         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_message_stream();
        test_input_backpressure();
        test_field_noise();

        // Let any late or spurious write show before the verdict.
        repeat (END_SETTLE) @(posedge clk);

        $display("Checked %0d requests and %0d digit writes (%0d requests with two writes).",
                 requests_taken, writes_checked, double_write_steps);
        $display("Text channel stalled for %0d cycles; %0d mismatches found.",
                 input_stall_cycles, error_count);
        if (error_count == 0 && digit_expected.size() == 0)
            $display("seven_segment_text_encoder regression: pass");
        else
            $display("seven_segment_text_encoder regression: fail");
        $finish;
    end

endmodule
